/* hdl/udrb_pkg.sv */
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared types and codes for the dual ring buffer uart core.
// ----------------------------------------------------------------------------
package udrb_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned DATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RX_BYTE  = 3'd0,
    FUNC_TX_EMPTY = 3'd1,
    FUNC_SEND     = 3'd2,
    FUNC_READ     = 3'd3,
    FUNC_CLEAR    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } ctrl_state_e;

  // command group from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic done;
  } ctrl_cmd_t;

endpackage

/* hdl/udrb_ctrl.sv */
// ----------------------------------------------------------------------------
// udrb_ctrl
// Sequencer: capture a command, execute it, strobe the result.
// ----------------------------------------------------------------------------
module udrb_ctrl import udrb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // a new command may be taken while the result is shown
        state_d = start_i ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o     = (state_q == ST_EXEC);
    cmd_o.load = start_i && (state_q != ST_EXEC);
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.done = (state_q == ST_DONE);
  end

endmodule

/* hdl/udrb_fifo.sv */
// ----------------------------------------------------------------------------
// udrb_fifo
// Power-of-two byte ring buffer with wrap-bit counters and registered read.
// ----------------------------------------------------------------------------
module udrb_fifo import udrb_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              pop_i,
  input  logic              clear_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic [AW:0]       level_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW:0]       head_q, head_d;
  logic [AW:0]       tail_q, tail_d;
  logic [DATA_W-1:0] rdata_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (clear_i) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (push_i) head_d = head_q + {{AW{1'b0}}, 1'b1};
      if (pop_i)  tail_d = tail_q + {{AW{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[head_q[AW-1:0]] <= wdata_i;
    if (pop_i)  rdata_q <= mem[tail_q[AW-1:0]];
  end

  // counters wrap at twice the depth, so the difference is the fill level
  assign level_o = head_q - tail_q;
  assign full_o  = level_o[AW];
  assign empty_o = (level_o == '0);
  assign rdata_o = rdata_q;

endmodule

/* hdl/udrb_datapath.sv */
// ----------------------------------------------------------------------------
// udrb_datapath
// Command register, both ring buffers, transmit restart logic and results.
// ----------------------------------------------------------------------------
module udrb_datapath import udrb_pkg::*; #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16,
  localparam int unsigned RX_AW = $clog2(RX_DEPTH),
  localparam int unsigned TX_AW = $clog2(TX_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              status_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic              line_tx_valid_o,
  output logic [DATA_W-1:0] line_tx_data_o,
  output logic              tx_irq_enable_o,
  output logic [RX_AW:0]    rx_level_o,
  output logic [TX_AW:0]    tx_level_o
);

  logic [FUNC_W-1:0] func_q;
  logic [DATA_W-1:0] data_q;

  logic rx_push, rx_pop, tx_push, tx_pop, clear;
  logic rx_full, rx_empty, tx_full, tx_empty;
  logic [DATA_W-1:0] rx_rdata, tx_rdata;

  logic restart_q, restart_d;
  logic irq_q, irq_d;
  logic status_q, status_d;
  logic rd_ok_q, rd_ok_d;
  logic tx_ok_q, tx_ok_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      data_q <= data_i;
    end
  end

  always_comb begin
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    clear     = 1'b0;
    restart_d = restart_q;
    irq_d     = irq_q;
    status_d  = status_q;
    rd_ok_d   = rd_ok_q;
    tx_ok_d   = tx_ok_q;
    if (cmd_i.exec) begin
      status_d = 1'b0;
      rd_ok_d  = 1'b0;
      tx_ok_d  = 1'b0;
      unique case (func_q)
        FUNC_RX_BYTE: begin
          if (rx_full) status_d = 1'b1;
          else         rx_push  = 1'b1;
        end
        FUNC_TX_EMPTY: begin
          if (!tx_empty) begin
            tx_pop    = 1'b1;
            tx_ok_d   = 1'b1;
            restart_d = 1'b0;
          end else begin
            // nothing queued: park the transmitter until the next send
            restart_d = 1'b1;
            irq_d     = 1'b0;
          end
        end
        FUNC_SEND: begin
          if (tx_full) begin
            status_d = 1'b1;
          end else begin
            tx_push = 1'b1;
            if (restart_q) begin
              restart_d = 1'b0;
              irq_d     = 1'b1;
            end
          end
        end
        FUNC_READ: begin
          if (rx_empty) begin
            status_d = 1'b1;
          end else begin
            rx_pop  = 1'b1;
            rd_ok_d = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          clear     = 1'b1;
          restart_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b1;
      irq_q     <= 1'b0;
      status_q  <= 1'b0;
      rd_ok_q   <= 1'b0;
      tx_ok_q   <= 1'b0;
    end else begin
      restart_q <= restart_d;
      irq_q     <= irq_d;
      status_q  <= status_d;
      rd_ok_q   <= rd_ok_d;
      tx_ok_q   <= tx_ok_d;
    end
  end

  udrb_fifo #(
    .DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rx_push),
    .pop_i   (rx_pop),
    .clear_i (clear),
    .wdata_i (data_q),
    .rdata_o (rx_rdata),
    .level_o (rx_level_o),
    .full_o  (rx_full),
    .empty_o (rx_empty)
  );

  udrb_fifo #(
    .DEPTH (TX_DEPTH)
  ) u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tx_push),
    .pop_i   (tx_pop),
    .clear_i (clear),
    .wdata_i (data_q),
    .rdata_o (tx_rdata),
    .level_o (tx_level_o),
    .full_o  (tx_full),
    .empty_o (tx_empty)
  );

  assign status_o        = status_q;
  assign read_data_o     = rd_ok_q ? rx_rdata : '0;
  assign line_tx_valid_o = tx_ok_q;
  assign line_tx_data_o  = tx_ok_q ? tx_rdata : '0;
  assign tx_irq_enable_o = irq_q;

endmodule

/* hdl/uart_dual_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer_core
// Receive and transmit byte ring buffers with transmit interrupt restart.
// ----------------------------------------------------------------------------
// A command (func_i, data_i) is taken when start_i is high and busy_o is low.
// The next cycle executes it against the buffers, with a registered memory
// read for pops, and the cycle after that shows the result for exactly one
// cycle with done_o high; the receiver cannot stall it. busy_o is high only
// in the execute cycle, so a new command can be given while a result is
// shown but is held off by busy_o while a command executes. tx_irq_enable_o
// and the level ports are valid with done_o and hold until the next command
// executes. RX_DEPTH and TX_DEPTH must be powers of two.
module uart_dual_ring_buffer_core import udrb_pkg::*; #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic [DATA_W-1:0]          data_i,
  output logic                       done_o,
  output logic                       status_o,
  output logic [DATA_W-1:0]          read_data_o,
  output logic                       line_tx_valid_o,
  output logic [DATA_W-1:0]          line_tx_data_o,
  output logic                       tx_irq_enable_o,
  output logic [$clog2(RX_DEPTH):0]  rx_level_o,
  output logic [$clog2(TX_DEPTH):0]  tx_level_o
);

  ctrl_cmd_t cmd;

  udrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  udrb_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .data_i          (data_i),
    .status_o        (status_o),
    .read_data_o     (read_data_o),
    .line_tx_valid_o (line_tx_valid_o),
    .line_tx_data_o  (line_tx_data_o),
    .tx_irq_enable_o (tx_irq_enable_o),
    .rx_level_o      (rx_level_o),
    .tx_level_o      (tx_level_o)
  );

  assign done_o = cmd.done;

`ifndef SYNTHESIS
  // every accepted command is followed by its execute cycle and then a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 done_o)
    else $error("accepted command did not produce a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_level_o <= ($clog2(RX_DEPTH)+1)'(RX_DEPTH)) &&
    (tx_level_o <= ($clog2(TX_DEPTH)+1)'(TX_DEPTH)))
    else $error("fifo level beyond depth");

  // after a byte goes to the line, the transmit fifo level is below full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && line_tx_valid_o) |-> (tx_level_o < ($clog2(TX_DEPTH)+1)'(TX_DEPTH)))
    else $error("line byte sent from a full transmit fifo");
`endif

endmodule
